[hw/rtl/mcpe_pkg.sv]
// ----------------------------------------------------------------------------
// mcpe_pkg
// Shared types and constants of the motor command packet engine: packet codes,
// event and setting selectors, limits, schedule slots and the decode record.
// ----------------------------------------------------------------------------
package mcpe_pkg;

	// field widths
	localparam int unsigned VAL_W  = 16;
	localparam int unsigned CMD_W  = 11;
	localparam int unsigned SLOT_W = 6;
	localparam int unsigned BYTE_W = 8;

	// parameter defaults
	localparam int unsigned STORE_DEPTH_DEF = 256;
	localparam int unsigned SLOT_COUNT_DEF  = 42;

	// limits
	localparam logic [VAL_W-1:0] CMD_MAX      = 16'd2000;
	localparam logic [VAL_W-1:0] RUD_SLOW_LIM = 16'd1000;
	localparam logic [VAL_W-1:0] CUR_MAX_HI   = 16'd5000;
	localparam logic [VAL_W-1:0] CUR_MAX_LO   = 16'd2000;
	localparam logic [VAL_W-1:0] TEMP_MAX     = 16'd10000;
	localparam logic [BYTE_W-1:0] SLEW_MAX    = 8'd250;
	localparam logic [BYTE_W-1:0] SLEW_MIN    = 8'd1;

	// schedule slots
	localparam logic [SLOT_W-1:0] SLOT_STAT0 = 6'd0;
	localparam logic [SLOT_W-1:0] SLOT_STAT1 = 6'd10;
	localparam logic [SLOT_W-1:0] SLOT_STAT2 = 6'd20;
	localparam logic [SLOT_W-1:0] SLOT_STAT3 = 6'd30;
	localparam logic [SLOT_W-1:0] SLOT_EE0   = 6'd16;
	localparam logic [SLOT_W-1:0] SLOT_EE1   = 6'd26;
	localparam logic [SLOT_W-1:0] SLOT_EE2   = 6'd36;

	// item kinds
	localparam logic ACT_PACKET = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// outgoing packet types
	localparam logic OUT_FLAGS = 1'b0;
	localparam logic OUT_EE    = 1'b1;

	typedef enum logic [3:0] {
		CODE_CMD       = 4'd0,
		CODE_MAXCUR    = 4'd1,
		CODE_CTRLTEMP  = 4'd2,
		CODE_MOTORTEMP = 4'd3,
		CODE_RUDMIN    = 4'd4,
		CODE_RUDMAX    = 4'd5,
		CODE_DISENGAGE = 4'd6,
		CODE_SLEW      = 4'd7,
		CODE_EEREAD    = 4'd8,
		CODE_EEWRITE   = 4'd9,
		CODE_RESET     = 4'd10
	} code_t;

	typedef enum logic [1:0] {
		EVT_NONE      = 2'd0,
		EVT_STOP      = 2'd1,
		EVT_ENGAGE    = 2'd2,
		EVT_DISENGAGE = 2'd3
	} evt_t;

	typedef enum logic [2:0] {
		SEL_NONE      = 3'd0,
		SEL_MAXCUR    = 3'd1,
		SEL_CTRLTEMP  = 3'd2,
		SEL_MOTORTEMP = 3'd3,
		SEL_RUDMIN    = 3'd4,
		SEL_RUDMAX    = 3'd5,
		SEL_SLEW      = 3'd6
	} sel_t;

	// decoded packet, handed from the decoder to the top level
	typedef struct packed {
		evt_t             evt;
		logic [CMD_W-1:0] cmd_val;
		logic             tmo_clr;
		sel_t             sel;
		logic [VAL_W-1:0] set_val;
		logic             clr_oc;
		logic             rd_range;
		logic             ee_wr;
	} pkt_res_t;

endpackage

[hw/rtl/mcpe_decode.sv]
// ----------------------------------------------------------------------------
// mcpe_decode
// Packet decoder: gates motor commands by range and fault flags, clamps the
// current, temperature and slew values and flags store and read-range requests.
// ----------------------------------------------------------------------------
module mcpe_decode (
	input  logic [3:0]                      code,
	input  logic [mcpe_pkg::BYTE_W-1:0]     cmd_lo,
	input  logic [mcpe_pkg::BYTE_W-1:0]     cmd_hi,
	input  logic [mcpe_pkg::VAL_W-1:0]      status_word,
	input  logic                            low_current_mode,
	output mcpe_pkg::pkt_res_t              res
);
	import mcpe_pkg::*;

	logic [VAL_W-1:0]  val;
	logic [VAL_W-1:0]  cur_lim;
	logic [BYTE_W-1:0] slew_lo;
	logic [BYTE_W-1:0] slew_hi;
	logic              fault;
	logic              hard_stop;
	logic              slow_stop;

	// clamp one slew byte to its legal range
	function automatic logic [BYTE_W-1:0] clamp_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		r = b;
		if (r > SLEW_MAX)
			r = SLEW_MAX;
		if (r == '0)
			r = SLEW_MIN;
		return r;
	endfunction

	// payload value and flag groups
	assign val       = {cmd_hi, cmd_lo};
	assign cur_lim   = low_current_mode ? CUR_MAX_LO : CUR_MAX_HI;
	assign slew_lo   = clamp_byte(cmd_lo);
	assign slew_hi   = clamp_byte(cmd_hi);
	assign fault     = |status_word[2:0];
	assign hard_stop = status_word[3] | status_word[5];
	assign slow_stop = (status_word[4] | status_word[6]) && (val < RUD_SLOW_LIM);

	// code decode
	always_comb begin
		res = '0;
		res.evt = EVT_NONE;
		res.sel = SEL_NONE;
		case (code_t'(code))
			CODE_CMD: begin
				res.tmo_clr = 1'b1;
				if (val <= CMD_MAX && !fault) begin
					if (hard_stop || slow_stop) begin
						res.evt = EVT_STOP;
					end else begin
						res.evt     = EVT_ENGAGE;
						res.cmd_val = val[CMD_W-1:0];
					end
				end
			end
			CODE_MAXCUR: begin
				res.sel     = SEL_MAXCUR;
				res.set_val = (val > cur_lim) ? cur_lim : val;
			end
			CODE_CTRLTEMP: begin
				res.sel     = SEL_CTRLTEMP;
				res.set_val = (val > TEMP_MAX) ? TEMP_MAX : val;
			end
			CODE_MOTORTEMP: begin
				res.sel     = SEL_MOTORTEMP;
				res.set_val = (val > TEMP_MAX) ? TEMP_MAX : val;
			end
			CODE_RUDMIN: begin
				res.sel     = SEL_RUDMIN;
				res.set_val = val;
			end
			CODE_RUDMAX: begin
				res.sel     = SEL_RUDMAX;
				res.set_val = val;
			end
			CODE_DISENGAGE: begin
				res.evt = EVT_DISENGAGE;
			end
			CODE_SLEW: begin
				res.sel     = SEL_SLEW;
				res.set_val = {slew_hi, slew_lo};
			end
			CODE_EEREAD: begin
				res.rd_range = 1'b1;
			end
			CODE_EEWRITE: begin
				res.ee_wr = 1'b1;
			end
			CODE_RESET: begin
				res.clr_oc = 1'b1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

[hw/rtl/mcpe_store.sv]
// ----------------------------------------------------------------------------
// mcpe_store
// Byte store with one write and one registered read port. Per-entry valid
// bits make every entry read as zero after reset until it is written.
// ----------------------------------------------------------------------------
module mcpe_store #(
	parameter int unsigned STORE_DEPTH = mcpe_pkg::STORE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [mcpe_pkg::BYTE_W-1:0] wr_addr,
	input  logic [mcpe_pkg::BYTE_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [mcpe_pkg::BYTE_W-1:0] rd_addr,
	output logic [mcpe_pkg::BYTE_W-1:0] rd_data
);
	import mcpe_pkg::*;

	localparam int unsigned AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int unsigned ADDR_N  = 1 << BYTE_W;

	logic [BYTE_W-1:0] mem [STORE_DEPTH];
	logic              vld_q [STORE_DEPTH];
	logic [AW-1:0]     idx_tab [ADDR_N];
	logic [AW-1:0]     wr_idx;
	logic [AW-1:0]     rd_idx;
	logic [BYTE_W-1:0] rd_q;
	logic              rd_vld_q;

	// address reduction modulo the depth, a constant table
	for (genvar g = 0; g < ADDR_N; g++) begin : g_idx
		assign idx_tab[g] = AW'(g % STORE_DEPTH);
	end

	assign wr_idx = idx_tab[wr_addr];
	assign rd_idx = idx_tab[rd_addr];

	// data array, no reset
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_idx];
	end

	// valid bits and registered valid of the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				vld_q[i] <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_idx] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_idx];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

[hw/rtl/motor_command_packet_engine.sv]
// ----------------------------------------------------------------------------
// motor_command_packet_engine
// Packet engine of a motor controller: decodes incoming packets and walks
// the outgoing slot schedule, with an EEPROM byte store.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel pkt_valid / pkt_stall carries action, code, cmd_lo, cmd_hi
//    and status_word; an item is taken when pkt_valid is high and pkt_stall
//    is low. action 0 is an incoming packet, action 1 an outgoing slot tick.
//  - result channel res_valid / res_stall returns exactly one result item
//    per input item, in the cycle after it is taken.
//  - one item per cycle sustained; the single output register is refilled in
//    the same cycle its result is taken, so pkt_stall only rises while a
//    result sits in the output register and res_stall is high.
//  - the EEPROM store is read at the accept edge of an EEPROM-sending tick and
//    written at the accept edge of a write packet, so a later item always sees
//    earlier writes; the read data register feeds the result directly.
//  - cfg_valid / cfg_ready writes low_current_mode; cfg_ready is always high.
//  - reset clears the slot position, the read range, the mode register and
//    the per-entry valid bits of the store at once, so every byte reads as
//    zero until written; there is no clearing pass.
// ----------------------------------------------------------------------------
module motor_command_packet_engine #(
	parameter int unsigned STORE_DEPTH = mcpe_pkg::STORE_DEPTH_DEF,
	parameter int unsigned SLOT_COUNT  = mcpe_pkg::SLOT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        low_current_mode,
	// input items
	input  logic                        pkt_valid,
	output logic                        pkt_stall,
	input  logic                        action,
	input  logic [3:0]                  code,
	input  logic [mcpe_pkg::BYTE_W-1:0] cmd_lo,
	input  logic [mcpe_pkg::BYTE_W-1:0] cmd_hi,
	input  logic [mcpe_pkg::VAL_W-1:0]  status_word,
	// result items
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [1:0]                  cmd_event,
	output logic [mcpe_pkg::CMD_W-1:0]  cmd_value,
	output logic                        timeout_clear,
	output logic [2:0]                  setting_sel,
	output logic [mcpe_pkg::VAL_W-1:0]  setting_value,
	output logic                        clear_overcurrent,
	output logic                        send,
	output logic                        out_type,
	output logic [mcpe_pkg::BYTE_W-1:0] out_lo,
	output logic [mcpe_pkg::BYTE_W-1:0] out_hi
);
	import mcpe_pkg::*;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

	logic              lcm_q;
	logic              res_valid_q;
	logic              acc;
	pkt_res_t          dec;
	logic              is_pkt;
	logic              is_tick;

	logic [SLOT_W-1:0] slot_pos_q;
	logic [BYTE_W-1:0] read_addr_q;
	logic [BYTE_W-1:0] end_addr_q;
	logic              stat_slot;
	logic              ee_slot;
	logic              ee_emit;
	logic              range_idle;

	logic [BYTE_W-1:0] rd_data;

	pkt_res_t          dec_s1;
	logic              send_s1;
	logic              type_s1;
	logic [BYTE_W-1:0] lo_s1;
	logic [BYTE_W-1:0] hi_s1;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcm_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			lcm_q <= low_current_mode;
		end
	end

	// handshake: stall only while a result waits and the receiver stalls
	assign pkt_stall = res_valid_q && res_stall;
	assign acc       = pkt_valid && !pkt_stall;
	assign is_pkt    = (action == ACT_PACKET);
	assign is_tick   = (action == ACT_TICK);

	// packet decode
	mcpe_decode u_decode (
		.code             (code),
		.cmd_lo           (cmd_lo),
		.cmd_hi           (cmd_hi),
		.status_word      (status_word),
		.low_current_mode (lcm_q),
		.res              (dec)
	);

	// schedule slot classification
	assign stat_slot  = (slot_pos_q == SLOT_STAT0) || (slot_pos_q == SLOT_STAT1) ||
	                    (slot_pos_q == SLOT_STAT2) || (slot_pos_q == SLOT_STAT3);
	assign ee_slot    = (slot_pos_q == SLOT_EE0) || (slot_pos_q == SLOT_EE1) ||
	                    (slot_pos_q == SLOT_EE2);
	assign range_idle = (read_addr_q == end_addr_q);
	assign ee_emit    = is_tick && !stat_slot && ee_slot && !range_idle;

	// byte store
	mcpe_store #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (acc && is_pkt && dec.ee_wr),
		.wr_addr (cmd_lo),
		.wr_data (cmd_hi),
		.rd_en   (acc && ee_emit),
		.rd_addr (read_addr_q),
		.rd_data (rd_data)
	);

	// schedule position and read range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_pos_q  <= '0;
			read_addr_q <= '0;
			end_addr_q  <= '0;
		end else if (acc) begin
			if (is_pkt && dec.rd_range && range_idle) begin
				read_addr_q <= cmd_lo;
				end_addr_q  <= cmd_hi;
			end
			if (ee_emit) begin
				read_addr_q <= read_addr_q + 1'b1;
			end
			if (is_tick && !ee_emit) begin
				slot_pos_q <= (slot_pos_q >= SLOT_LAST) ? '0 : slot_pos_q + 1'b1;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (acc) begin
			dec_s1  <= is_pkt ? dec : '0;
			send_s1 <= is_tick && (stat_slot || ee_emit);
			type_s1 <= ee_emit ? OUT_EE : OUT_FLAGS;
			lo_s1   <= ee_emit ? read_addr_q :
			           (is_tick && stat_slot) ? status_word[7:0] : '0;
			hi_s1   <= (is_tick && stat_slot) ? status_word[15:8] : '0;
		end
	end

	assign res_valid         = res_valid_q;
	assign cmd_event         = dec_s1.evt;
	assign cmd_value         = dec_s1.cmd_val;
	assign timeout_clear     = dec_s1.tmo_clr;
	assign setting_sel       = dec_s1.sel;
	assign setting_value     = dec_s1.set_val;
	assign clear_overcurrent = dec_s1.clr_oc;
	assign send              = send_s1;
	assign out_type          = type_s1;
	assign out_lo            = lo_s1;
	assign out_hi            = (type_s1 == OUT_EE) ? rd_data : hi_s1;

`ifndef SYNTHESIS
	// the schedule position stays inside the schedule
	assert property (@(posedge clk) disable iff (!arst_n)
		slot_pos_q <= SLOT_LAST)
		else $error("slot position beyond schedule");

	// the read range moves only when an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(read_addr_q) && $stable(end_addr_q))
		else $error("read range changed without an item");

	// an eeprom byte goes out only while the schedule holds its slot
	assert property (@(posedge clk) disable iff (!arst_n)
		acc && ee_emit |=> $stable(slot_pos_q))
		else $error("slot advanced on an eeprom send");

	// a tick result carries no packet decode
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && send |-> setting_sel == SEL_NONE && cmd_event == EVT_NONE)
		else $error("tick result with packet fields");

	// an eeprom packet is always a sent packet
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_type == OUT_EE |-> send)
		else $error("eeprom packet type without send");
`endif

endmodule
